// File: rtl/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
package bgc_pkg;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned GESTURE_W = 2;

	typedef logic [CFG_W-1:0] cfg_word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [GESTURE_W-1:0] gesture_t;

	localparam cfg_idx_t REG_LONG_PRESS = 1'd0;
	localparam cfg_idx_t REG_RELEASE_WINDOW = 1'd1;

	localparam cfg_word_t LONG_PRESS_RESET = 16'd600;
	localparam cfg_word_t RELEASE_WINDOW_RESET = 16'd100;

	localparam phase_t PH_IDLE = 3'd0;
	localparam phase_t PH_DEBOUNCE = 3'd1;
	localparam phase_t PH_HOLD = 3'd2;
	localparam phase_t PH_GAP = 3'd3;
	localparam phase_t PH_SECOND = 3'd4;

	localparam gesture_t G_CLICK = 2'd0;
	localparam gesture_t G_LONG = 2'd1;
	localparam gesture_t G_DOUBLE = 2'd2;

endpackage

// File: rtl/button_gesture_classifier_unit.sv
// Top level of the button gesture classifier: tick register, phase machine, result register.
//
// channel | direction | handshake               | payload
// in      | request   | in_valid / in_stall     | pin_level
// out     | result    | out_valid / out_stall   | gesture
// cfg     | write     | cfg_we                  | cfg_index, cfg_wdata
//
// One tick per cycle while in_stall is low; a tick is first held in the tick register, then
// updates the phase machine and the result register once out_stall lets it advance.
// arst_n clears the phase, counters, valid flags and loads register defaults.
// in_stall rises only when a finished result is held by out_stall and a tick waits.
module button_gesture_classifier_unit #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       pin_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bgc_pkg::gesture_t          gesture,
	input  logic                       cfg_we,
	input  bgc_pkg::cfg_idx_t          cfg_index,
	input  bgc_pkg::cfg_word_t         cfg_wdata
);

	localparam int unsigned CMP_W = (COUNT_BITS > bgc_pkg::CFG_W) ? COUNT_BITS : bgc_pkg::CFG_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	bgc_pkg::cfg_word_t long_press_q;
	bgc_pkg::cfg_word_t release_window_q;

	logic valid_s1;
	logic pin_s1;

	bgc_pkg::phase_t phase_q;
	logic [COUNT_BITS-1:0] hold_q;
	logic [COUNT_BITS-1:0] gap_q;

	logic out_valid_q;
	bgc_pkg::gesture_t gesture_q;

	logic advance;
	logic pressed;
	logic [COUNT_BITS-1:0] hold_inc;
	logic [COUNT_BITS-1:0] gap_inc;
	logic window_open;
	logic is_long;

	bgc_pkg::phase_t phase_d;
	logic [COUNT_BITS-1:0] hold_d;
	logic [COUNT_BITS-1:0] gap_d;
	logic emit;
	bgc_pkg::gesture_t gesture_d;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign gesture = gesture_q;

	assign pressed = !pin_s1;
	assign hold_inc = (hold_q == COUNT_MAX) ? hold_q : hold_q + 1'b1;
	assign gap_inc = (gap_q == COUNT_MAX) ? gap_q : gap_q + 1'b1;
	assign window_open = (CMP_W'(gap_inc) < CMP_W'(release_window_q)) && (gap_inc != COUNT_MAX);
	assign is_long = CMP_W'(hold_q) >= CMP_W'(long_press_q);

	always_comb begin
		phase_d = phase_q;
		hold_d = hold_q;
		gap_d = gap_q;
		emit = 1'b0;
		gesture_d = bgc_pkg::G_CLICK;
		unique case (phase_q)
			bgc_pkg::PH_IDLE: begin
				if (pressed) begin
					phase_d = bgc_pkg::PH_DEBOUNCE;
				end
			end
			bgc_pkg::PH_DEBOUNCE: begin
				phase_d = pressed ? bgc_pkg::PH_HOLD : bgc_pkg::PH_IDLE;
			end
			bgc_pkg::PH_HOLD: begin
				if (pressed) begin
					hold_d = hold_inc;
				end else begin
					phase_d = bgc_pkg::PH_GAP;
				end
			end
			bgc_pkg::PH_GAP: begin
				if (pressed) begin
					phase_d = bgc_pkg::PH_SECOND;
					gap_d = '0;
				end else if (window_open) begin
					gap_d = gap_inc;
				end else begin
					emit = 1'b1;
					gesture_d = is_long ? bgc_pkg::G_LONG : bgc_pkg::G_CLICK;
					phase_d = bgc_pkg::PH_IDLE;
					hold_d = '0;
					gap_d = '0;
				end
			end
			bgc_pkg::PH_SECOND: begin
				if (pressed) begin
					gap_d = gap_inc;
				end else begin
					emit = 1'b1;
					gesture_d = bgc_pkg::G_DOUBLE;
					phase_d = bgc_pkg::PH_IDLE;
					hold_d = '0;
					gap_d = '0;
				end
			end
			default: begin
				phase_d = bgc_pkg::PH_IDLE;
				hold_d = '0;
				gap_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= bgc_pkg::LONG_PRESS_RESET;
			release_window_q <= bgc_pkg::RELEASE_WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgc_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata;
				bgc_pkg::REG_RELEASE_WINDOW: release_window_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bgc_pkg::PH_IDLE;
			hold_q <= '0;
			gap_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			hold_q <= hold_d;
			gap_q <= gap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			gesture_q <= gesture_d;
		end
	end

endmodule
